[hw/rtl/sh24_pkg.sv]
// ----------------------------------------------------------------------------
// sh24_pkg
// Shared types, constants, the SipRound function and the control store of
// the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
package sh24_pkg;

    // Initialization constants ("somepseudorandomlygeneratedbytes")
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    // Finalization marker XORed into v2
    localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

    // Key reset values
    localparam logic [63:0] KEY_LOW_RST  = 64'h0706050403020100;
    localparam logic [63:0] KEY_HIGH_RST = 64'h0f0e0d0c0b0a0908;

    // Default round counts
    localparam int unsigned COMPRESSION_ROUNDS_DEF = 2;
    localparam int unsigned FINAL_ROUNDS_DEF       = 4;

    // Configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Full word byte count
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // Chain state v0..v3
    typedef logic [3:0][63:0] chain_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_ROUND_M,
        OP_LOAD_LEN,
        OP_FIN,
        OP_ROUND,
        OP_EMIT
    } op_t;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_ROUNDS,
        COND_NO_LEN,
        COND_CNT_LOOP,
        COND_OUT_FREE
    } cond_t;

    typedef logic [2:0] step_t;

    // Program step addresses
    localparam step_t ST_IDLE = 3'd0;
    localparam step_t ST_COMP = 3'd1;
    localparam step_t ST_CHK  = 3'd2;
    localparam step_t ST_LEN  = 3'd3;
    localparam step_t ST_FIN  = 3'd4;
    localparam step_t ST_FRND = 3'd5;
    localparam step_t ST_EMIT = 3'd6;

    // One control word
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t tgt;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic go;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic cnt_more;   // more than one round left
        logic word_more;  // message continues after this word
        logic need_len;   // length-only final word still due
        logic out_free;   // result register can take a value
    } status_t;

    // Control store
    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        unique case (pc)
            ST_IDLE: w = '{op: OP_ACCEPT,   cond: COND_IN_VALID, tgt: ST_COMP};
            ST_COMP: w = '{op: OP_ROUND_M,  cond: COND_ROUNDS,   tgt: ST_IDLE};
            ST_CHK:  w = '{op: OP_NOP,      cond: COND_NO_LEN,   tgt: ST_FIN};
            ST_LEN:  w = '{op: OP_LOAD_LEN, cond: COND_ALWAYS,   tgt: ST_COMP};
            ST_FIN:  w = '{op: OP_FIN,      cond: COND_ALWAYS,   tgt: ST_FRND};
            ST_FRND: w = '{op: OP_ROUND,    cond: COND_CNT_LOOP, tgt: ST_EMIT};
            ST_EMIT: w = '{op: OP_EMIT,     cond: COND_OUT_FREE, tgt: ST_IDLE};
            default: w = '{op: OP_NOP,      cond: COND_ALWAYS,   tgt: ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
        return (x << s) | (x >> (64 - s));
    endfunction

    // One SipRound
    function automatic chain_t sip_round(input chain_t v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
        c = c + d; d = rotl(d, 16); d = d ^ c;
        a = a + d; d = rotl(d, 21); d = d ^ a;
        c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
        return {d, c, b, a};
    endfunction

endpackage

[hw/rtl/sh24_seq.sv]
// ----------------------------------------------------------------------------
// sh24_seq
// Microcode sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module sh24_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  sh24_pkg::status_t status,
    output sh24_pkg::ctrl_t   ctrl
);

    sh24_pkg::step_t  pc_reg;
    sh24_pkg::step_t  pc_next;
    sh24_pkg::uword_t uw;

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= sh24_pkg::ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Fetch and branch
    always_comb begin
        uw      = sh24_pkg::ucode(pc_reg);
        ctrl.op = uw.op;
        ctrl.go = 1'b1;
        pc_next = pc_reg + 3'd1;
        unique case (uw.cond)
            sh24_pkg::COND_ALWAYS: begin
                pc_next = uw.tgt;
            end
            sh24_pkg::COND_IN_VALID: begin
                ctrl.go = s_valid;
                pc_next = s_valid ? uw.tgt : pc_reg;
            end
            sh24_pkg::COND_ROUNDS: begin
                if (status.cnt_more) begin
                    pc_next = pc_reg;
                end else if (status.word_more) begin
                    pc_next = uw.tgt;
                end
            end
            sh24_pkg::COND_NO_LEN: begin
                if (!status.need_len) begin
                    pc_next = uw.tgt;
                end
            end
            sh24_pkg::COND_CNT_LOOP: begin
                pc_next = status.cnt_more ? pc_reg : uw.tgt;
            end
            sh24_pkg::COND_OUT_FREE: begin
                ctrl.go = status.out_free;
                pc_next = status.out_free ? uw.tgt : pc_reg;
            end
            default: begin
                pc_next = sh24_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/sh24_dp.sv]
// ----------------------------------------------------------------------------
// sh24_dp
// Datapath: key and chain registers, one shared SipRound unit, message and
// length registers, round counter and result register.
// ----------------------------------------------------------------------------
module sh24_dp #(
    parameter int unsigned COMPRESSION_ROUNDS = sh24_pkg::COMPRESSION_ROUNDS_DEF,
    parameter int unsigned FINAL_ROUNDS       = sh24_pkg::FINAL_ROUNDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sh24_pkg::ctrl_t   ctrl,
    output sh24_pkg::status_t status,
    input  logic [63:0]       s_data_word,
    input  logic [3:0]        s_byte_count,
    input  logic              s_last_word,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [63:0]       m_hash_value
);

    localparam int unsigned RoundMax =
        (COMPRESSION_ROUNDS > FINAL_ROUNDS) ? COMPRESSION_ROUNDS : FINAL_ROUNDS;
    localparam int unsigned CntW = $clog2(RoundMax + 1);

    logic [63:0]      key_low_reg;
    logic [63:0]      key_high_reg;
    sh24_pkg::chain_t v_reg, v_next;
    logic [63:0]      m_reg, m_next;
    logic [7:0]       len_reg, len_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             in_msg_reg, in_msg_next;
    logic             word_more_reg, word_more_next;
    logic             need_len_reg, need_len_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      hash_reg, hash_next;

    sh24_pkg::chain_t init_v;
    sh24_pkg::chain_t base_v;
    sh24_pkg::chain_t round_in;
    sh24_pkg::chain_t round_out;
    logic [3:0]       cnt_sat;
    logic             full;
    logic [7:0]       len_new;
    logic [63:0]      byte_mask;
    logic [63:0]      m_in;
    logic [63:0]      len_word;

    // Key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= sh24_pkg::KEY_LOW_RST;
            key_high_reg <= sh24_pkg::KEY_HIGH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sh24_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                sh24_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                default:                key_low_reg  <= key_low_reg;
            endcase
        end
    end

    // Input word shaping: saturated count, byte mask, length byte
    always_comb begin
        cnt_sat = (s_byte_count > sh24_pkg::WORD_BYTES) ? sh24_pkg::WORD_BYTES
                                                        : s_byte_count;
        full    = (cnt_sat == sh24_pkg::WORD_BYTES);
        len_new = (in_msg_reg ? len_reg : 8'd0) + {4'd0, cnt_sat};
        for (int i = 0; i < 8; i++) begin
            byte_mask[i*8 +: 8] = {8{(4'(i) < cnt_sat)}};
        end
        m_in     = full ? s_data_word : ((s_data_word & byte_mask) | {len_new, 56'd0});
        len_word = {len_reg, 56'd0};
    end

    // Start state and shared round unit
    always_comb begin
        init_v[0] = sh24_pkg::SIP_C0 ^ key_low_reg;
        init_v[1] = sh24_pkg::SIP_C1 ^ key_high_reg;
        init_v[2] = sh24_pkg::SIP_C2 ^ key_low_reg;
        init_v[3] = sh24_pkg::SIP_C3 ^ key_high_reg;
        base_v    = in_msg_reg ? v_reg : init_v;
        round_in  = v_reg;
        if (ctrl.op == sh24_pkg::OP_ACCEPT) begin
            round_in    = base_v;
            round_in[3] = base_v[3] ^ m_in;
        end
        round_out = sh24_pkg::sip_round(round_in);
    end

    // Operation decode
    always_comb begin
        v_next         = v_reg;
        m_next         = m_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        in_msg_next    = in_msg_reg;
        word_more_next = word_more_reg;
        need_len_next  = need_len_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        if (ctrl.go) begin
            unique case (ctrl.op)
                sh24_pkg::OP_ACCEPT: begin
                    v_next = round_out;
                    if (COMPRESSION_ROUNDS == 1) begin
                        v_next[0] = round_out[0] ^ m_in;
                    end
                    m_next         = m_in;
                    len_next       = len_new;
                    cnt_next       = CntW'(COMPRESSION_ROUNDS - 1);
                    in_msg_next    = 1'b1;
                    word_more_next = full & ~s_last_word;
                    need_len_next  = full & s_last_word;
                end
                sh24_pkg::OP_ROUND_M: begin
                    if (cnt_reg != '0) begin
                        v_next = round_out;
                        if (cnt_reg == CntW'(1)) begin
                            v_next[0] = round_out[0] ^ m_reg;
                        end
                        cnt_next = cnt_reg - CntW'(1);
                    end
                end
                sh24_pkg::OP_LOAD_LEN: begin
                    m_next        = len_word;
                    v_next[3]     = v_reg[3] ^ len_word;
                    cnt_next      = CntW'(COMPRESSION_ROUNDS);
                    need_len_next = 1'b0;
                end
                sh24_pkg::OP_FIN: begin
                    v_next[2] = v_reg[2] ^ sh24_pkg::FIN_MARK;
                    cnt_next  = CntW'(FINAL_ROUNDS);
                end
                sh24_pkg::OP_ROUND: begin
                    v_next   = round_out;
                    cnt_next = cnt_reg - CntW'(1);
                end
                sh24_pkg::OP_EMIT: begin
                    hash_next      = v_reg[0] ^ v_reg[1] ^ v_reg[2] ^ v_reg[3];
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    len_next       = 8'd0;
                end
                default: begin
                    v_next = v_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= 8'd0;
            cnt_reg       <= '0;
            in_msg_reg    <= 1'b0;
            word_more_reg <= 1'b0;
            need_len_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            in_msg_reg    <= in_msg_next;
            word_more_reg <= word_more_next;
            need_len_reg  <= need_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        m_reg    <= m_next;
        hash_reg <= hash_next;
    end

    assign status.cnt_more  = (cnt_reg > CntW'(1));
    assign status.word_more = word_more_reg;
    assign status.need_len  = need_len_reg;
    assign status.out_free  = ~out_valid_reg | m_ready;

    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

endmodule

[hw/rtl/siphash_2_4_mac.sv]
// Compression: a full word occupies the block for COMPRESSION_ROUNDS SipRounds (2 by
//   default), one SipRound per cycle through the single shared round unit.
// Last word: its rounds are followed by the finalization step, FINAL_ROUNDS SipRounds
//   and the emit step, which registers the result; 8 bytes add a length word first.
// Reset (aresetn, synchronous): key returns to its default, no message open,
//   no result pending; the chain words are loaded at the first word of a message.
// ----------------------------------------------------------------------------
// siphash_2_4_mac
// SipHash-2-4 keyed hash engine: microcode sequencer driving a one-round
// datapath; key written through a plain configuration port.
// ----------------------------------------------------------------------------
module siphash_2_4_mac #(
    parameter int unsigned COMPRESSION_ROUNDS = sh24_pkg::COMPRESSION_ROUNDS_DEF,
    parameter int unsigned FINAL_ROUNDS       = sh24_pkg::FINAL_ROUNDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata
);

    sh24_pkg::ctrl_t   ctrl;
    sh24_pkg::status_t status;

    // Sequencer
    sh24_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Datapath
    sh24_dp #(
        .COMPRESSION_ROUNDS (COMPRESSION_ROUNDS),
        .FINAL_ROUNDS       (FINAL_ROUNDS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .status       (status),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // Items are taken only at the accept step, never in reset
    assign s_ready = aresetn && (ctrl.op == sh24_pkg::OP_ACCEPT);

endmodule
